// ----- rtl/rms_pkg.sv -----
// Shared constants and types for the repeated matrix squaring block.
package rms_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int SQ_W    = 8;
  localparam int CNT_W   = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CNT_W-1:0] CNT_SAT   = 7'd127;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [SQ_W-1:0]  SQ_RESET  = 8'd1;

  localparam logic REG_DIM = 1'b0;
  localparam logic REG_SQ  = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- rtl/repeated_matrix_squaring.sv -----
// Top level: loads an n x n matrix, squares it square_count times, streams the result.
// Load: one element per cycle; the load ends on the beat that fills n*n elements.
// Per squaring: S_COMP multiply-accumulates, S_CDRN drains, S_COPY copies the n^2 products back, then S_PDRN.
// Output: n^2 strobes, one per cycle, registered from the S_OUT state that follows the last squaring.
// Throughput is set by the single MAC pipeline and the two read ports of the matrix memory.
// Reset (sync, active-low) clears control and load count, presets config; memories are not cleared.
module repeated_matrix_squaring import rms_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_element_value,
  output logic                      out_strobe,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [IDX_W-1:0]          out_result_row,
  output logic [IDX_W-1:0]          out_result_col,
  output logic                      out_result_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int TW    = $clog2(CELLS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_CDRN = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_PDRN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [DIM_W-1:0] matrix_dim_r;
  logic [SQ_W-1:0]  square_count_r;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt, cnt_inc;
  logic [RW-1:0]    r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic             drn_r, drn_nxt;
  logic             cp_v_r, cp_v_nxt;
  logic [AW-1:0]    cp_addr_r, cp_addr_nxt;
  logic             out_v_r, out_v_nxt;
  logic [RW-1:0]    out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic             out_last_r, out_last_nxt;

  logic [NW-1:0]    dim_n;
  logic [TW-1:0]    total;
  logic [RW-1:0]    nm1;
  logic [AW-1:0]    last_idx;
  logic             accept, load_done, ld_we, cfg_wr;

  logic [AW-1:0]         a_addr, b_addr, w_addr;
  logic                  mat_we;
  logic [AW-1:0]         mat_waddr, mat_raddr_a;
  logic [DATA_WIDTH-1:0] mat_wdata, mat_rd_a, mat_rd_b, ld_data;
  logic [DATA_WIDTH-1:0] prod_rd;
  logic                  pst_we;
  logic [AW-1:0]         pst_waddr;
  logic [DATA_WIDTH-1:0] pst_wdata;
  mac_ctl_t              issue_ctl;

  always_comb begin
    if (matrix_dim_r == '0) begin
      dim_n = NW'(1);
    end else if (int'(matrix_dim_r) > MAX_DIM) begin
      dim_n = NW'(MAX_DIM);
    end else begin
      dim_n = NW'(matrix_dim_r);
    end
  end

  assign total    = TW'(dim_n) * TW'(dim_n);
  assign nm1      = RW'(dim_n - NW'(1));
  assign last_idx = AW'(total - TW'(1));

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign cnt_inc   = (load_cnt_r == CNT_SAT) ? load_cnt_r : load_cnt_r + CNT_W'(1);
  assign load_done = (int'(cnt_inc) >= int'(total));
  assign ld_we     = accept & (int'(load_cnt_r) < CELLS);
  assign ld_data   = DATA_WIDTH'(in_element_value);

  assign a_addr = AW'(int'(r_r) * int'(dim_n) + int'(k_r));
  assign b_addr = AW'(int'(k_r) * int'(dim_n) + int'(c_r));
  assign w_addr = AW'(int'(r_r) * int'(dim_n) + int'(c_r));

  assign issue_ctl.valid = (state_r == S_COMP);
  assign issue_ctl.first = (k_r == '0);
  assign issue_ctl.last  = (k_r == nm1);

  assign mat_we      = cp_v_r | ld_we;
  assign mat_waddr   = cp_v_r ? cp_addr_r : load_cnt_r[AW-1:0];
  assign mat_wdata   = cp_v_r ? prod_rd : ld_data;
  assign mat_raddr_a = (state_r == S_OUT) ? idx_r : a_addr;

  rms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_matrix_ram (
    .clk       (clk),
    .wr_en     (mat_we),
    .wr_addr   (mat_waddr),
    .wr_data   (mat_wdata),
    .rd_addr_a (mat_raddr_a),
    .rd_addr_b (b_addr),
    .rd_data_a (mat_rd_a),
    .rd_data_b (mat_rd_b)
  );

  rms_mac #(.DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_ctl  (issue_ctl),
    .issue_addr (w_addr),
    .a_data     (mat_rd_a),
    .b_data     (mat_rd_b),
    .wr_en      (pst_we),
    .wr_addr    (pst_waddr),
    .wr_data    (pst_wdata)
  );

  rms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_product_ram (
    .clk       (clk),
    .wr_en     (pst_we),
    .wr_addr   (pst_waddr),
    .wr_data   (pst_wdata),
    .rd_addr_a (idx_r),
    .rd_addr_b ('0),
    .rd_data_a (prod_rd),
    .rd_data_b ()
  );

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    sq_nxt       = sq_r;
    drn_nxt      = drn_r;
    cp_v_nxt     = 1'b0;
    cp_addr_nxt  = idx_r;
    out_v_nxt    = 1'b0;
    out_row_nxt  = r_r;
    out_col_nxt  = c_r;
    out_last_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_cnt_nxt = cnt_inc;
          if (load_done) begin
            load_cnt_nxt = '0;
            r_nxt        = '0;
            c_nxt        = '0;
            k_nxt        = '0;
            idx_nxt      = '0;
            sq_nxt       = square_count_r;
            state_nxt    = (square_count_r == '0) ? S_OUT : S_COMP;
          end
        end
      end
      S_COMP: begin
        if (k_r != nm1) begin
          k_nxt = k_r + RW'(1);
        end else begin
          k_nxt = '0;
          if (c_r != nm1) begin
            c_nxt = c_r + RW'(1);
          end else begin
            c_nxt = '0;
            if (r_r != nm1) begin
              r_nxt = r_r + RW'(1);
            end else begin
              r_nxt     = '0;
              drn_nxt   = 1'b0;
              state_nxt = S_CDRN;
            end
          end
        end
      end
      S_CDRN: begin
        if (drn_r) begin
          idx_nxt   = '0;
          state_nxt = S_COPY;
        end else begin
          drn_nxt = 1'b1;
        end
      end
      S_COPY: begin
        cp_v_nxt    = 1'b1;
        cp_addr_nxt = idx_r;
        if (idx_r == last_idx) begin
          state_nxt = S_PDRN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_PDRN: begin
        r_nxt   = '0;
        c_nxt   = '0;
        k_nxt   = '0;
        idx_nxt = '0;
        if (sq_r == SQ_W'(1)) begin
          state_nxt = S_OUT;
        end else begin
          sq_nxt    = sq_r - SQ_W'(1);
          state_nxt = S_COMP;
        end
      end
      S_OUT: begin
        out_v_nxt    = 1'b1;
        out_row_nxt  = r_r;
        out_col_nxt  = c_r;
        out_last_nxt = (idx_r == last_idx);
        idx_nxt      = idx_r + AW'(1);
        if (c_r != nm1) begin
          c_nxt = c_r + RW'(1);
        end else begin
          c_nxt = '0;
          r_nxt = r_r + RW'(1);
        end
        if (idx_r == last_idx) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      load_cnt_r     <= '0;
      drn_r          <= 1'b0;
      cp_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      matrix_dim_r   <= DIM_RESET;
      square_count_r <= SQ_RESET;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      drn_r      <= drn_nxt;
      cp_v_r     <= cp_v_nxt;
      out_v_r    <= out_v_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_DIM: matrix_dim_r   <= pwdata[DIM_W-1:0];
          REG_SQ:  square_count_r <= pwdata[SQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    sq_r       <= sq_nxt;
    cp_addr_r  <= cp_addr_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIM: prdata = APB_DW'(matrix_dim_r);
      REG_SQ:  prdata = APB_DW'(square_count_r);
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign out_strobe       = out_v_r;
  assign out_result_value = VALUE_W'(mat_rd_a);
  assign out_result_row   = IDX_W'(out_row_r);
  assign out_result_col   = IDX_W'(out_col_r);
  assign out_result_last  = out_last_r;

endmodule

// ----- rtl/rms_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module rms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                       rd_data_a,
  output logic [WIDTH-1:0]                       rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/rms_mac.sv -----
// Multiply-accumulate pipeline producing one dot product per output element.
module rms_mac import rms_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_ctl_t              issue_ctl,
  input  logic [AW-1:0]         issue_addr,
  input  logic [DATA_WIDTH-1:0] a_data,
  input  logic [DATA_WIDTH-1:0] b_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data
);

  mac_ctl_t              s1_ctl_r, s2_ctl_r;
  logic [AW-1:0]         s1_addr_r, s2_addr_r;
  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= issue_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= issue_addr;
    s2_addr_r <= s1_addr_r;
    if (s2_ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  generate
    if (DATA_WIDTH <= 32) begin : g_narrow
      logic [DATA_WIDTH-1:0] prod_r;
      always_ff @(posedge clk) begin
        prod_r <= DATA_WIDTH'(a_data * b_data);
      end
      assign prod = prod_r;
    end else begin : g_wide
      localparam int HW = DATA_WIDTH - 32;
      logic [63:0]   p0_r;
      logic [HW-1:0] cross_r;
      always_ff @(posedge clk) begin
        p0_r    <= 64'(a_data[31:0]) * 64'(b_data[31:0]);
        cross_r <= HW'(a_data[31:0] * b_data[DATA_WIDTH-1:32])
                 + HW'(a_data[DATA_WIDTH-1:32] * b_data[31:0]);
      end
      assign prod = DATA_WIDTH'(p0_r) + {cross_r, 32'b0};
    end
  endgenerate

  assign acc_nxt = (s2_ctl_r.first ? '0 : acc_r) + prod;
  assign wr_en   = s2_ctl_r.valid & s2_ctl_r.last;
  assign wr_addr = s2_addr_r;
  assign wr_data = acc_nxt;

endmodule
